// ===== rtl/positional_circular_list_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Positional circular list assertion macros
// Shared concurrent assertion forms for the positional circular list RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_CIRCULAR_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional circular list check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional circular list check failed");

`endif

// ===== rtl/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional circular list package
// Command and status codes, cell control codes and shared types.
// ----------------------------------------------------------------------------
package pcl_pkg;

   // Width of a cell index; a 1-based position field holds up to 63.
   localparam int IDX_W  = 6;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_DUMP      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_DUMP = 2'b10
   } fsm_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cell_op_type              op;
      logic [IDX_W-1:0]         sel;
      logic [IDX_W-1:0]         tail;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== rtl/pcl_cell.sv =====
// ----------------------------------------------------------------------------
// Positional circular list cell
// Holds one list element and moves it toward either neighbor on command.
// ----------------------------------------------------------------------------
module pcl_cell import pcl_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic signed [DATA_W-1:0] head_data,
   output logic signed [DATA_W-1:0] data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_INSERT: begin
            if (MY_IDX > ctrl.sel) begin
               data_in = left_data;
            end else if (MY_IDX == ctrl.sel) begin
               data_in = ctrl.value;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= ctrl.sel) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // The tail cell closes the ring by taking the head element.
            if (MY_IDX == ctrl.tail) begin
               data_in = head_data;
            end else if (MY_IDX < ctrl.tail) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/positional_circular_list_unit.sv =====
// ----------------------------------------------------------------------------
// Positional circular list unit
// Ordered store of signed 32-bit values edited by positional commands.
// ----------------------------------------------------------------------------
// An insert or delete command is accepted when start is high and busy is
// low, and its single result (status and new count) appears with rsp_valid
// in the next cycle. A dump of n stored values yields n results on
// consecutive cycles, starting the cycle after acceptance, with rsp_last on
// the final one; busy stays high after a dump is accepted until the final
// result is issued. A dump of an empty store yields one result without an
// item. The chain of cells shifts by one place per cycle, and a dump rotates
// the ring one element per cycle. There is no backpressure: each result is
// on the rsp_ ports for exactly one cycle and must be taken then.
// ----------------------------------------------------------------------------
`include "positional_circular_list_unit_defines.svh"

module positional_circular_list_unit import pcl_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [IDX_W-1:0]         req_position,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [5:0]               rsp_element_count,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_has_item,
   output logic                     rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > IDX_W) ? CW : IDX_W) + 1;

   logic signed [DATA_W-1:0] cell_data  [CAPACITY];
   logic signed [DATA_W-1:0] left_data  [CAPACITY];
   logic signed [DATA_W-1:0] right_data [CAPACITY];
   cell_ctrl_type            cell_ctrl;

   fsm_type          state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    dump_idx_ff, dump_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [5:0]               rsp_count_ff, rsp_count_in;
   logic signed [DATA_W-1:0] rsp_item_ff, rsp_item_in;
   logic                     rsp_has_item_ff, rsp_has_item_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic          ins_pos_ok;
   logic          del_pos_ok;
   logic          dump_last;
   logic [PW-1:0] pos_w;
   logic [PW-1:0] cnt_w;

   // Cell chain.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_data[g] = cell_data[g];
      end else begin : g_mid_left
         assign left_data[g] = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_data[g] = cell_data[g];
      end else begin : g_mid_right
         assign right_data[g] = cell_data[g+1];
      end

      pcl_cell #(
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .left_data  (left_data[g]),
         .right_data (right_data[g]),
         .head_data  (cell_data[0]),
         .data       (cell_data[g])
      );
   end

   assign busy   = (state_ff == FSM_DUMP);
   assign accept = start && !busy;
   assign full   = (count_ff >= CW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign pos_w  = PW'(req_position);
   assign cnt_w  = PW'(count_ff);
   assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
   assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
   assign dump_last  = (dump_idx_ff == count_ff - CW'(1));

   always_comb begin
      cell_ctrl.op    = CELL_HOLD;
      cell_ctrl.sel   = '0;
      cell_ctrl.tail  = IDX_W'(count_ff - CW'(1));
      cell_ctrl.value = req_value;

      state_in        = state_ff;
      count_in        = count_ff;
      dump_idx_in     = dump_idx_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = ST_OK;
      rsp_item_in     = '0;
      rsp_has_item_in = 1'b0;
      rsp_last_in     = 1'b1;

      unique case (state_ff)
         FSM_IDLE: begin
            rsp_valid_in = accept;
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else if (cmd_type'(req_cmd) == CMD_INS_FRONT) begin
                        cell_ctrl.op = CELL_INSERT;
                        cell_ctrl.sel = '0;
                        count_in = count_ff + CW'(1);
                     end else if (cmd_type'(req_cmd) == CMD_INS_BACK) begin
                        cell_ctrl.op = CELL_INSERT;
                        cell_ctrl.sel = IDX_W'(count_ff);
                        count_in = count_ff + CW'(1);
                     end else if (!ins_pos_ok) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        cell_ctrl.op = CELL_INSERT;
                        cell_ctrl.sel = req_position - IDX_W'(1);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (cmd_type'(req_cmd) == CMD_DEL_FRONT) begin
                        cell_ctrl.op = CELL_DELETE;
                        cell_ctrl.sel = '0;
                        count_in = count_ff - CW'(1);
                     end else if (cmd_type'(req_cmd) == CMD_DEL_BACK) begin
                        cell_ctrl.op = CELL_DELETE;
                        cell_ctrl.sel = IDX_W'(count_ff - CW'(1));
                        count_in = count_ff - CW'(1);
                     end else if (!del_pos_ok) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        cell_ctrl.op = CELL_DELETE;
                        cell_ctrl.sel = req_position - IDX_W'(1);
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (!empty) begin
                        // The head goes out now and the ring turns by one.
                        cell_ctrl.op = CELL_ROTATE;
                        rsp_item_in = cell_data[0];
                        rsp_has_item_in = 1'b1;
                        rsp_last_in = (count_ff == CW'(1));
                        dump_idx_in = CW'(1);
                        if (count_ff != CW'(1)) begin
                           state_in = FSM_DUMP;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         FSM_DUMP: begin
            cell_ctrl.op    = CELL_ROTATE;
            rsp_valid_in    = 1'b1;
            rsp_item_in     = cell_data[0];
            rsp_has_item_in = 1'b1;
            rsp_last_in     = dump_last;
            dump_idx_in     = dump_idx_ff + CW'(1);
            if (dump_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rsp_count_in = 6'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_item_ff     <= rsp_item_in;
      rsp_has_item_ff <= rsp_has_item_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_item          = rsp_item_ff;
   assign rsp_has_item      = rsp_has_item_ff;
   assign rsp_last          = rsp_last_ff;

   `PCL_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `PCL_ASSERT_SAME(a_dump_index, clock, reset, state_ff == FSM_DUMP,
      (count_ff > CW'(1)) && (dump_idx_ff < count_ff))
   `PCL_ASSERT_NEXT(a_dump_stream, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   `PCL_ASSERT_NEXT(a_edit_result, clock, reset,
      accept && (req_cmd != CMD_DUMP), rsp_valid && rsp_last && !rsp_has_item)

endmodule

// ===== dv/pcl_list_checker.sv =====
// ----------------------------------------------------------------------------
// Positional circular list checker
// Watches the command and result channels of the list unit, keeps its own
// copy of the ordered store, predicts each result and compares it field by
// field with what the unit produces.
// ----------------------------------------------------------------------------
module pcl_list_checker import pcl_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [2:0]               req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [IDX_W-1:0]         req_position,
   input  logic                     rsp_valid,
   input  logic [1:0]               rsp_status,
   input  logic [5:0]               rsp_element_count,
   input  logic signed [DATA_W-1:0] rsp_item,
   input  logic                     rsp_has_item,
   input  logic                     rsp_last,
   output int                       failures,
   output int                       pending,
   output logic [5:0]               fill_level
);

   typedef struct {
      status_type               status;
      logic [5:0]               count;
      logic signed [DATA_W-1:0] item;
      logic                     has_item;
      logic                     last;
   } list_result_type;

   list_result_type          awaited_results[$];
   logic signed [DATA_W-1:0] list_values[$];
   int                       bad_results = 0;

   function automatic void queue_result(input status_type st,
                                        input logic signed [DATA_W-1:0] item,
                                        input logic has, input logic last);
      list_result_type r;
      r.status   = st;
      r.count    = 6'(list_values.size());
      r.item     = item;
      r.has_item = has;
      r.last     = last;
      awaited_results.push_back(r);
   endfunction

   // Applies one command to the shadow list and queues the results it causes.
   function automatic void apply_list_command(input logic [2:0] cmd,
                                              input logic signed [DATA_W-1:0] v,
                                              input logic [IDX_W-1:0] pos);
      int         n;
      status_type st;
      n  = list_values.size();
      st = ST_OK;
      case (cmd)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
            // Fullness wins over a bad position.
            if (n >= CAPACITY) st = ST_FULL;
            else if (cmd == CMD_INS_FRONT) list_values.push_front(v);
            else if (cmd == CMD_INS_BACK) list_values.push_back(v);
            else if (pos < 1 || pos > n + 1) st = ST_BADPOS;
            else list_values.insert(int'(pos) - 1, v);
         end
         CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
            // Emptiness wins over a bad position.
            if (n == 0) st = ST_EMPTY;
            else if (cmd == CMD_DEL_FRONT) void'(list_values.pop_front());
            else if (cmd == CMD_DEL_BACK) void'(list_values.pop_back());
            else if (pos < 1 || pos > n) st = ST_BADPOS;
            else list_values.delete(int'(pos) - 1);
         end
         CMD_DUMP: begin
            if (n == 0) begin
               queue_result(ST_OK, '0, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  queue_result(ST_OK, list_values[i], 1'b1, i == n - 1);
            end
            return;
         end
         default: ;  // The unused code leaves the list alone but still answers.
      endcase
      queue_result(st, '0, 1'b0, 1'b1);
   endfunction

   function automatic void note_failure(input string msg);
      bad_results++;
      if (bad_results <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         list_values.delete();
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               note_failure($sformatf(
                  "unexpected result: status=%0d count=%0d item=%0d has=%0b last=%0b",
                  rsp_status, rsp_element_count, rsp_item, rsp_has_item, rsp_last));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status || rsp_element_count !== want.count ||
                   rsp_item !== want.item || rsp_has_item !== want.has_item ||
                   rsp_last !== want.last)
                  note_failure($sformatf({"result mismatch: expected status=%0d count=%0d ",
                     "item=%0d has=%0b last=%0b, got status=%0d count=%0d item=%0d ",
                     "has=%0b last=%0b"},
                     want.status, want.count, want.item, want.has_item, want.last,
                     rsp_status, rsp_element_count, rsp_item, rsp_has_item, rsp_last));
            end
         end
         // A command transfer is predicted after the result of this edge has
         // been matched, since its own results only start on the next cycle.
         if (start && !busy) apply_list_command(req_cmd, req_value, req_position);
      end
      failures   <= bad_results;
      pending    <= awaited_results.size();
      fill_level <= 6'(list_values.size());
   end

endmodule

// ===== dv/tb_positional_circular_list_unit.sv =====
// ----------------------------------------------------------------------------
// Positional circular list unit testbench
// Drives directed edge cases and then grow, shrink and mixed random command
// traffic with bursty pacing into the list unit; a separate checker predicts
// every result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_positional_circular_list_unit;
   import pcl_pkg::*;

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam int         CYCLE_LIMIT = 60000;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [2:0]               req_cmd = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [IDX_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [5:0]               rsp_element_count;
   logic signed [DATA_W-1:0] rsp_item;
   logic                     rsp_has_item;
   logic                     rsp_last;
   int                       failures;
   int                       pending;
   logic [5:0]               fill_level;
   int                       cycles = 0;
   int                       burst_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   positional_circular_list_unit #(.CAPACITY(32)) uut (
      .clock, .reset, .start, .busy, .req_cmd, .req_value, .req_position,
      .rsp_valid, .rsp_status, .rsp_element_count, .rsp_item, .rsp_has_item,
      .rsp_last
   );

   pcl_list_checker #(.CAPACITY(32)) list_check (
      .clock, .reset, .start, .busy, .req_cmd, .req_value, .req_position,
      .rsp_valid, .rsp_status, .rsp_element_count, .rsp_item, .rsp_has_item,
      .rsp_last, .failures, .pending, .fill_level
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Holds the command until the edge at which the transfer happens.
   task automatic send_item(input logic [2:0] c, input logic signed [DATA_W-1:0] v,
                            input logic [IDX_W-1:0] p);
      start        <= 1'b1;
      req_cmd      <= c;
      req_value    <= v;
      req_position <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // The fill level seen here may lag by one transfer, which only shifts a
   // few positions onto the boundaries.
   function automatic logic [IDX_W-1:0] pick_position(input bit for_insert);
      int top_pos;
      int r;
      top_pos = for_insert ? fill_level + 1 : fill_level;
      r = $urandom_range(0, 99);
      if (r < 70) return (top_pos < 1) ? IDX_W'(1) : IDX_W'($urandom_range(1, top_pos));
      else if (r < 80) return '0;
      else if (r < 90) return IDX_W'(top_pos + 1);
      else return IDX_W'($urandom_range(0, 63));
   endfunction

   task automatic random_item(input traffic_mix_type mix);
      int         r;
      logic [2:0] c;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (r < 28) c = CMD_INS_FRONT;
            else if (r < 54) c = CMD_INS_BACK;
            else if (r < 82) c = CMD_INS_AT;
            else if (r < 90) c = 3'($urandom_range(CMD_DEL_FRONT, CMD_DEL_AT));
            else if (r < 98) c = CMD_DUMP;
            else c = CMD_UNUSED;
         end
         MIX_SHRINK: begin
            if (r < 27) c = CMD_DEL_FRONT;
            else if (r < 54) c = CMD_DEL_BACK;
            else if (r < 82) c = CMD_DEL_AT;
            else if (r < 90) c = 3'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
            else if (r < 98) c = CMD_DUMP;
            else c = CMD_UNUSED;
         end
         default: begin
            c = (r < 4) ? CMD_UNUSED : 3'($urandom_range(CMD_INS_FRONT, CMD_DUMP));
         end
      endcase
      send_item(c, pick_value(), pick_position(c == CMD_INS_AT));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty store: dump, every delete, and inserts at bad positions.
      send_item(CMD_DUMP, '0, '0);
      send_item(CMD_DEL_FRONT, '0, '0);
      send_item(CMD_DEL_BACK, '0, '0);
      send_item(CMD_DEL_AT, '0, 6'd0);
      send_item(CMD_INS_AT, 32'h1234_5678, 6'd0);
      send_item(CMD_INS_AT, 32'h1234_5678, 6'd2);
      // Build a small list with extreme values.
      send_item(CMD_INS_AT, 32'h8000_0000, 6'd1);
      send_item(CMD_INS_FRONT, 32'h7fff_ffff, 6'd63);
      send_item(CMD_INS_BACK, '1, '0);
      send_item(CMD_INS_BACK, '0, '0);
      send_item(CMD_INS_AT, 32'h5555_5555, 6'd6);
      send_item(CMD_INS_AT, 32'h5555_5555, 6'd63);
      send_item(CMD_INS_AT, 32'haaaa_aaaa, 6'd5);
      send_item(CMD_INS_AT, 32'h0f0f_0f0f, 6'd3);
      send_item(CMD_DUMP, '0, '0);
      send_item(CMD_DEL_AT, '0, 6'd0);
      send_item(CMD_DEL_AT, '0, 6'd7);
      send_item(CMD_DEL_AT, '0, 6'd63);
      send_item(CMD_DEL_AT, '0, 6'd6);
      send_item(CMD_DEL_AT, '0, 6'd1);
      send_item(CMD_UNUSED, '1, '1);
      send_item(CMD_DEL_FRONT, '0, '0);
      send_item(CMD_DEL_BACK, '0, '0);
      send_item(CMD_DUMP, '0, '0);
      wait_drained();

      // Grow toward capacity, shrink back down, then mixed traffic.
      repeat (50) begin
         pace_sender();
         random_item(MIX_GROW);
      end
      wait_drained();
      repeat (40) begin
         pace_sender();
         random_item(MIX_SHRINK);
      end
      repeat (10) begin
         pace_sender();
         random_item(MIX_EVEN);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (failures == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
